FILE: hdl/report_debounce_and_smooth_macros.svh
// Assertion macros shared by the report debounce and smoothing block.
`ifndef REPORT_DEBOUNCE_AND_SMOOTH_MACROS_SVH
`define REPORT_DEBOUNCE_AND_SMOOTH_MACROS_SVH

// Property sampled on clk, off while rst is high.
`define RDAS_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Condition in one cycle implies a condition in the next.
`define RDAS_ASSERT_NEXT(name, pre, post, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);

`endif

FILE: hdl/rdas_pkg.sv
// Types, constants and helpers for the report debounce and smoothing block.
package rdas_pkg;

  localparam int DEPTH              = 3;
  localparam int NUM_BUTTONS        = 3;
  localparam int NUM_CONTROLS       = 5;
  localparam int NUM_PULSE_CONTROLS = 3;
  localparam int NUM_AXES           = 2;

  typedef logic [7:0] byte_t;
  typedef logic [1:0] slot_t;
  typedef logic [9:0] axis_sum_t;

  localparam byte_t PULSE_MODE  = 8'h18;
  localparam byte_t MODE_RESET  = 8'h06;
  localparam slot_t LAST_SLOT   = 2'd2;
  // floor(x / 3) == (x * 683) >> 11 for every x up to 3 * 255
  localparam axis_sum_t DIV3_MUL = 10'd683;

  // Per-request control from the top level to the history units.
  typedef struct packed {
    logic advance;  // request moves from input register to result register
    logic pulse;    // wheel mode selects pulse mode
  } step_t;

  function automatic slot_t next_slot(input slot_t s);
    return (s == LAST_SLOT) ? '0 : s + 2'd1;
  endfunction

  function automatic byte_t div3(input axis_sum_t x);
    logic [19:0] prod;
    prod = x * DIV3_MUL;
    return prod[18:11];
  endfunction

endpackage

FILE: hdl/rdas_debounce.sv
// Button and control byte histories with three-sample AND debounce; in pulse mode control bytes 3..4 pass through.
`include "report_debounce_and_smooth_macros.svh"

module rdas_debounce (
  input  logic                                         clk,
  input  logic                                         rst,
  input  rdas_pkg::step_t                              step,
  input  rdas_pkg::byte_t [rdas_pkg::NUM_BUTTONS-1:0]  button_in,
  input  rdas_pkg::byte_t [rdas_pkg::NUM_CONTROLS-1:0] control_in,
  output rdas_pkg::byte_t [rdas_pkg::NUM_BUTTONS-1:0]  button_out,
  output rdas_pkg::byte_t [rdas_pkg::NUM_CONTROLS-1:0] control_out
);
  import rdas_pkg::*;

  byte_t [NUM_BUTTONS-1:0]  button_ring       [DEPTH];
  byte_t [NUM_BUTTONS-1:0]  button_ring_next  [DEPTH];
  byte_t [NUM_CONTROLS-1:0] control_ring      [DEPTH];
  byte_t [NUM_CONTROLS-1:0] control_ring_next [DEPTH];
  slot_t                    button_slot;
  slot_t                    control_slot;
  slot_t                    cpos;

  // pulse mode shares the button write position
  assign cpos = step.pulse ? button_slot : control_slot;

  always_comb begin
    button_ring_next  = button_ring;
    control_ring_next = control_ring;
    button_ring_next[button_slot] = button_in;
    for (int i = 0; i < NUM_CONTROLS; i++) begin
      if (!step.pulse || i < NUM_PULSE_CONTROLS) begin
        control_ring_next[cpos][i] = control_in[i];
      end
    end
    for (int i = 0; i < NUM_BUTTONS; i++) begin
      button_out[i] = button_ring_next[0][i] & button_ring_next[1][i] & button_ring_next[2][i];
    end
    for (int i = 0; i < NUM_CONTROLS; i++) begin
      if (step.pulse && i >= NUM_PULSE_CONTROLS) begin
        control_out[i] = control_in[i];
      end else begin
        control_out[i] = control_ring_next[0][i] & control_ring_next[1][i]
                       & control_ring_next[2][i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      button_ring  <= '{default: '0};
      control_ring <= '{default: '0};
      button_slot  <= '0;
      control_slot <= '0;
    end else if (step.advance) begin
      button_ring  <= button_ring_next;
      control_ring <= control_ring_next;
      button_slot  <= next_slot(button_slot);
      if (!step.pulse) begin
        control_slot <= next_slot(control_slot);
      end
    end
  end

  `RDAS_ASSERT(a_slots_in_range, (button_slot != 2'd3) && (control_slot != 2'd3), "write position out of range")
  `RDAS_ASSERT_NEXT(a_pulse_holds_cslot, step.advance && step.pulse, $stable(control_slot), "control position moved in pulse mode")
  `RDAS_ASSERT_NEXT(a_bslot_moves, step.advance, button_slot != $past(button_slot), "button position did not advance")

endmodule

FILE: hdl/rdas_axis_avg.sv
// Axis histories with floor mean of the last three samples.
module rdas_axis_avg (
  input  logic                                     clk,
  input  logic                                     rst,
  input  rdas_pkg::step_t                          step,
  input  rdas_pkg::byte_t [rdas_pkg::NUM_AXES-1:0] axis_in,
  output rdas_pkg::byte_t [rdas_pkg::NUM_AXES-1:0] axis_out
);
  import rdas_pkg::*;

  byte_t [NUM_AXES-1:0] axis_ring      [DEPTH];
  byte_t [NUM_AXES-1:0] axis_ring_next [DEPTH];
  slot_t                axis_slot;
  axis_sum_t            total [NUM_AXES];

  always_comb begin
    axis_ring_next = axis_ring;
    axis_ring_next[axis_slot] = axis_in;
    for (int i = 0; i < NUM_AXES; i++) begin
      total[i] = {2'b00, axis_ring_next[0][i]} + {2'b00, axis_ring_next[1][i]}
               + {2'b00, axis_ring_next[2][i]};
      axis_out[i] = div3(total[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      axis_ring <= '{default: '0};
      axis_slot <= '0;
    end else if (step.advance) begin
      axis_ring <= axis_ring_next;
      axis_slot <= next_slot(axis_slot);
    end
  end

endmodule

FILE: hdl/report_debounce_and_smooth.sv
// Top level: input register, history units and result register.
//
//  channel  | handshake               | payload
//  ---------+-------------------------+--------------------------------------------
//  in       | in_valid / in_stall     | button_byte_0..2, control_byte_0..4, axis_byte_0..1
//  out      | out_valid / out_stall   | filtered_button_0..2, filtered_control_0..4,
//           |                         | smoothed_axis_0..1
//  cfg      | cfg_valid / cfg_ready   | cfg_data (mode select)
//
// Results are registered; one request per cycle sustained while out_stall is low.
// The history rings update as a request moves from the input register to the result register.
// rst clears the rings, write positions, both valid flags and sets the mode select to 0x06.
// out_stall holds the result; the input register then fills and in_stall rises.
// cfg_ready is always high.
module report_debounce_and_smooth (
  input  logic            clk,
  input  logic            rst,
  input  logic            cfg_valid,
  output logic            cfg_ready,
  input  rdas_pkg::byte_t cfg_data,
  input  logic            in_valid,
  output logic            in_stall,
  input  rdas_pkg::byte_t button_byte_0,
  input  rdas_pkg::byte_t button_byte_1,
  input  rdas_pkg::byte_t button_byte_2,
  input  rdas_pkg::byte_t control_byte_0,
  input  rdas_pkg::byte_t control_byte_1,
  input  rdas_pkg::byte_t control_byte_2,
  input  rdas_pkg::byte_t control_byte_3,
  input  rdas_pkg::byte_t control_byte_4,
  input  rdas_pkg::byte_t axis_byte_0,
  input  rdas_pkg::byte_t axis_byte_1,
  output logic            out_valid,
  input  logic            out_stall,
  output rdas_pkg::byte_t filtered_button_0,
  output rdas_pkg::byte_t filtered_button_1,
  output rdas_pkg::byte_t filtered_button_2,
  output rdas_pkg::byte_t filtered_control_0,
  output rdas_pkg::byte_t filtered_control_1,
  output rdas_pkg::byte_t filtered_control_2,
  output rdas_pkg::byte_t filtered_control_3,
  output rdas_pkg::byte_t filtered_control_4,
  output rdas_pkg::byte_t smoothed_axis_0,
  output rdas_pkg::byte_t smoothed_axis_1
);
  import rdas_pkg::*;

  byte_t                    mode_sel;
  logic                     in_full;
  byte_t [NUM_BUTTONS-1:0]  button_reg;
  byte_t [NUM_CONTROLS-1:0] control_reg;
  byte_t [NUM_AXES-1:0]     axis_reg;
  byte_t [NUM_BUTTONS-1:0]  button_res;
  byte_t [NUM_CONTROLS-1:0] control_res;
  byte_t [NUM_AXES-1:0]     axis_res;
  byte_t [NUM_BUTTONS-1:0]  button_out_reg;
  byte_t [NUM_CONTROLS-1:0] control_out_reg;
  byte_t [NUM_AXES-1:0]     axis_out_reg;
  step_t                    step;
  logic                     accept;

  assign cfg_ready    = 1'b1;
  assign step.advance = in_full && (!out_valid || !out_stall);
  assign step.pulse   = (mode_sel == PULSE_MODE);
  assign in_stall     = in_full && !step.advance;
  assign accept       = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode_sel   <= MODE_RESET;
      in_full    <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        mode_sel <= cfg_data;
      end
      if (accept) begin
        in_full <= 1'b1;
      end else if (step.advance) begin
        in_full <= 1'b0;
      end
      if (step.advance) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      button_reg  <= {button_byte_2, button_byte_1, button_byte_0};
      control_reg <= {control_byte_4, control_byte_3, control_byte_2,
                      control_byte_1, control_byte_0};
      axis_reg    <= {axis_byte_1, axis_byte_0};
    end
    if (step.advance) begin
      button_out_reg  <= button_res;
      control_out_reg <= control_res;
      axis_out_reg    <= axis_res;
    end
  end

  rdas_debounce u_debounce (
    .clk         (clk),
    .rst         (rst),
    .step        (step),
    .button_in   (button_reg),
    .control_in  (control_reg),
    .button_out  (button_res),
    .control_out (control_res)
  );

  rdas_axis_avg u_axis_avg (
    .clk      (clk),
    .rst      (rst),
    .step     (step),
    .axis_in  (axis_reg),
    .axis_out (axis_res)
  );

  assign filtered_button_0  = button_out_reg[0];
  assign filtered_button_1  = button_out_reg[1];
  assign filtered_button_2  = button_out_reg[2];
  assign filtered_control_0 = control_out_reg[0];
  assign filtered_control_1 = control_out_reg[1];
  assign filtered_control_2 = control_out_reg[2];
  assign filtered_control_3 = control_out_reg[3];
  assign filtered_control_4 = control_out_reg[4];
  assign smoothed_axis_0    = axis_out_reg[0];
  assign smoothed_axis_1    = axis_out_reg[1];

endmodule
